// ===== src/tapd_pkg.sv =====
package tapd_pkg;

	// Field and datapath widths.
	localparam int DATA_W = 16;
	localparam int ERR_W = DATA_W + 1;
	localparam int NUM_W = 25;
	localparam int MAG_W = NUM_W - 1;
	localparam int QUO_W = 15;
	localparam int WSTAR_W = 15;
	localparam int PHASE_W = 2;
	localparam int CFG_IDX_W = 1;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PH_WIND = 2'd0;
	localparam logic [PHASE_W-1:0] PH_SWING = 2'd1;
	localparam logic [PHASE_W-1:0] PH_FOLLOW = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RANGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEARING = 1'd1;

	// Set points and sequencer thresholds.
	localparam int WIND_ANGLE = -1450;
	localparam int RELEASE_AT = -785;
	localparam int COCK_ANGLE = 1100;
	localparam int SETTLE_BAND = 120;
	localparam int SETTLE_RATE = 250;

	// Gains.
	localparam int YAW_KP = 200;
	localparam int YAW_KD = 40;
	localparam int ELB_KP = 220;
	localparam int ELB_KD = 40;
	localparam int WIND_KP = 260;
	localparam int WIND_KD = 50;
	localparam int SWING_KP = 120;
	localparam int FOLLOW_KP = 200;
	localparam int FOLLOW_KD = 40;

	// Division by 1000 as a multiply by ceil(2^34/1000); exact for magnitudes below 2^24.
	localparam int DIV_SHIFT = 34;
	localparam logic [24:0] DIV_RECIP = 25'd17179870;
	localparam int DIV_PROD_W = MAG_W + 25;

	// Swing speed: floor(range*294/1000) as a multiply by ceil(2^26*294/1000), plus WSTAR_BASE.
	localparam int WSTAR_SHIFT = 26;
	localparam logic [24:0] WSTAR_RECIP = 25'd19730007;
	localparam int WSTAR_PROD_W = DATA_W + 25;
	localparam logic [WSTAR_W-1:0] WSTAR_BASE = 15'd1374;

	typedef struct packed {
		logic signed [DATA_W-1:0] yaw_angle;
		logic signed [DATA_W-1:0] yaw_rate;
		logic signed [DATA_W-1:0] elbow_angle;
		logic signed [DATA_W-1:0] elbow_rate;
		logic signed [DATA_W-1:0] shoulder_angle;
		logic signed [DATA_W-1:0] shoulder_rate;
	} tapd_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] yaw_torque;
		logic signed [DATA_W-1:0] elbow_torque;
		logic signed [DATA_W-1:0] shoulder_torque;
		logic release_pulse;
		logic [PHASE_W-1:0] phase_now;
	} tapd_out_t;

	// Control-law results ahead of the divide: magnitude and sign per joint.
	typedef struct packed {
		logic [MAG_W-1:0] yaw_mag;
		logic yaw_neg;
		logic [MAG_W-1:0] elbow_mag;
		logic elbow_neg;
		logic [MAG_W-1:0] shoulder_mag;
		logic shoulder_neg;
		logic release_pulse;
		logic [PHASE_W-1:0] phase_now;
	} tapd_law_t;

	// Numerator of a PD law: err*kp - rate*kd.
	function automatic logic signed [NUM_W-1:0] pd_num(
		input logic signed [ERR_W-1:0] err,
		input logic signed [DATA_W-1:0] rate,
		input int kp,
		input int kd
	);
		logic signed [NUM_W-1:0] e;
		logic signed [NUM_W-1:0] r;
		e = NUM_W'(err);
		r = NUM_W'(rate);
		return e * NUM_W'(kp) - r * NUM_W'(kd);
	endfunction

	// Magnitude of a numerator; the sign is its top bit.
	function automatic logic [MAG_W-1:0] num_mag(input logic signed [NUM_W-1:0] num);
		logic signed [NUM_W-1:0] neg_num;
		neg_num = -num;
		return num[NUM_W-1] ? neg_num[MAG_W-1:0] : num[MAG_W-1:0];
	endfunction

	// Quotient of a magnitude by 1000.
	function automatic logic [QUO_W-1:0] div1000(input logic [MAG_W-1:0] mag);
		logic [DIV_PROD_W-1:0] prod;
		prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_RECIP);
		return QUO_W'(prod >> DIV_SHIFT);
	endfunction

	// Swing speed target from the range register.
	function automatic logic [WSTAR_W-1:0] swing_speed(input logic [DATA_W-1:0] range);
		logic [WSTAR_PROD_W-1:0] prod;
		prod = WSTAR_PROD_W'(range) * WSTAR_PROD_W'(WSTAR_RECIP);
		return WSTAR_W'(prod >> WSTAR_SHIFT) + WSTAR_BASE;
	endfunction

endpackage

// ===== src/tapd_in_if.sv =====
interface tapd_in_if;
	logic valid;
	logic ready;
	tapd_pkg::tapd_in_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== src/tapd_out_if.sv =====
interface tapd_out_if;
	logic valid;
	logic ready;
	tapd_pkg::tapd_out_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== src/tapd_law.sv =====
module tapd_law (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input tapd_pkg::tapd_in_t sample,
	input logic signed [tapd_pkg::DATA_W-1:0] bearing,
	input logic [tapd_pkg::WSTAR_W-1:0] wstar,
	output tapd_pkg::tapd_law_t law
);

	logic [tapd_pkg::PHASE_W-1:0] phase_q;
	logic [tapd_pkg::PHASE_W-1:0] phase_next;
	logic release_hit;
	logic signed [tapd_pkg::ERR_W-1:0] yaw_err;
	logic signed [tapd_pkg::ERR_W-1:0] elbow_err;
	logic signed [tapd_pkg::ERR_W-1:0] wind_err;
	logic signed [tapd_pkg::ERR_W-1:0] swing_err;
	logic signed [tapd_pkg::ERR_W-1:0] follow_err;
	logic signed [tapd_pkg::NUM_W-1:0] yaw_num;
	logic signed [tapd_pkg::NUM_W-1:0] elbow_num;
	logic signed [tapd_pkg::NUM_W-1:0] shoulder_num;
	logic settled;
	logic at_release;

	// Position and speed errors of each joint.
	always_comb begin
		yaw_err = tapd_pkg::ERR_W'(bearing) - tapd_pkg::ERR_W'(sample.yaw_angle);
		elbow_err = ((phase_q == tapd_pkg::PH_WIND) ?
			tapd_pkg::ERR_W'(tapd_pkg::COCK_ANGLE) : tapd_pkg::ERR_W'(0))
			- tapd_pkg::ERR_W'(sample.elbow_angle);
		wind_err = tapd_pkg::ERR_W'(tapd_pkg::WIND_ANGLE)
			- tapd_pkg::ERR_W'(sample.shoulder_angle);
		swing_err = $signed({2'b00, wstar}) - tapd_pkg::ERR_W'(sample.shoulder_rate);
		follow_err = tapd_pkg::ERR_W'(0) - tapd_pkg::ERR_W'(sample.shoulder_angle);
	end

	// Phase exit conditions.
	assign settled = (sample.shoulder_angle <= (tapd_pkg::WIND_ANGLE + tapd_pkg::SETTLE_BAND))
		&& (sample.shoulder_rate <= tapd_pkg::SETTLE_RATE)
		&& (sample.shoulder_rate >= -tapd_pkg::SETTLE_RATE);
	assign at_release = (sample.shoulder_angle >= tapd_pkg::RELEASE_AT)
		&& (sample.shoulder_rate > 0);

	// Yaw and elbow laws do not depend on the sequencer beyond the elbow set point.
	assign yaw_num = tapd_pkg::pd_num(yaw_err, sample.yaw_rate,
		tapd_pkg::YAW_KP, tapd_pkg::YAW_KD);
	assign elbow_num = tapd_pkg::pd_num(elbow_err, sample.elbow_rate,
		tapd_pkg::ELB_KP, tapd_pkg::ELB_KD);

	// Sequencer: shoulder law and next phase from the phase at the start of the tick.
	always_comb begin
		phase_next = phase_q;
		release_hit = 1'b0;
		case (phase_q)
			tapd_pkg::PH_WIND: begin
				shoulder_num = tapd_pkg::pd_num(wind_err, sample.shoulder_rate,
					tapd_pkg::WIND_KP, tapd_pkg::WIND_KD);
				if (settled) begin
					phase_next = tapd_pkg::PH_SWING;
				end
			end
			tapd_pkg::PH_SWING: begin
				shoulder_num = tapd_pkg::pd_num(swing_err, tapd_pkg::DATA_W'(0),
					tapd_pkg::SWING_KP, 0);
				if (at_release) begin
					phase_next = tapd_pkg::PH_FOLLOW;
					release_hit = 1'b1;
				end
			end
			default: begin
				shoulder_num = tapd_pkg::pd_num(follow_err, sample.shoulder_rate,
					tapd_pkg::FOLLOW_KP, tapd_pkg::FOLLOW_KD);
			end
		endcase
	end

	// Split numerators into magnitude and sign for the unsigned divide.
	always_comb begin
		law.yaw_mag = tapd_pkg::num_mag(yaw_num);
		law.yaw_neg = yaw_num[tapd_pkg::NUM_W-1];
		law.elbow_mag = tapd_pkg::num_mag(elbow_num);
		law.elbow_neg = elbow_num[tapd_pkg::NUM_W-1];
		law.shoulder_mag = tapd_pkg::num_mag(shoulder_num);
		law.shoulder_neg = shoulder_num[tapd_pkg::NUM_W-1];
		law.release_pulse = release_hit;
		law.phase_now = phase_next;
	end

	// Phase register moves once per request that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tapd_pkg::PH_WIND;
		end else if (advance) begin
			phase_q <= phase_next;
		end
	end

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q))
		else $error("phase changed without a request");
	a_follow_final: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tapd_pkg::PH_FOLLOW |=> phase_q == tapd_pkg::PH_FOLLOW)
		else $error("left follow-through");
	a_release_phase: assert property (@(posedge clk) disable iff (!arst_n)
		release_hit |-> (phase_q == tapd_pkg::PH_SWING && phase_next == tapd_pkg::PH_FOLLOW))
		else $error("release outside swing exit");

endmodule

// ===== src/tapd_scale.sv =====
module tapd_scale (
	input tapd_pkg::tapd_law_t law,
	output tapd_pkg::tapd_out_t result
);

	logic [tapd_pkg::QUO_W-1:0] yaw_quo;
	logic [tapd_pkg::QUO_W-1:0] elbow_quo;
	logic [tapd_pkg::QUO_W-1:0] shoulder_quo;
	logic [tapd_pkg::DATA_W-1:0] yaw_ext;
	logic [tapd_pkg::DATA_W-1:0] elbow_ext;
	logic [tapd_pkg::DATA_W-1:0] shoulder_ext;

	// Divide the magnitudes by 1000; truncation of the magnitude rounds toward zero.
	assign yaw_quo = tapd_pkg::div1000(law.yaw_mag);
	assign elbow_quo = tapd_pkg::div1000(law.elbow_mag);
	assign shoulder_quo = tapd_pkg::div1000(law.shoulder_mag);

	assign yaw_ext = {1'b0, yaw_quo};
	assign elbow_ext = {1'b0, elbow_quo};
	assign shoulder_ext = {1'b0, shoulder_quo};

	// Restore the sign and pass the sequencer flags along.
	always_comb begin
		result.yaw_torque = law.yaw_neg ? -yaw_ext : yaw_ext;
		result.elbow_torque = law.elbow_neg ? -elbow_ext : elbow_ext;
		result.shoulder_torque = law.shoulder_neg ? -shoulder_ext : shoulder_ext;
		result.release_pulse = law.release_pulse;
		result.phase_now = law.phase_now;
	end

endmodule

// ===== src/throw_arm_pd_sequencer_core.sv =====
// Three-joint PD torque controller with a wind-back, swing and follow-through
// sequencer. One request carries the six joint angles and rates of a tick and
// yields one result: three torques, the release pulse and the phase after the
// tick. A request is taken every cycle unless a stalled output fills all stages;
// its result passes through the input register, the law register and the result
// register before it is offered, and a stalled result only holds the
// stages behind it. Each of the two logic stages has one level of multiply:
// the constant-gain numerators, then a reciprocal multiply for the divide by 1000.
// The swing speed target is computed when target_range is written, so both
// configuration registers apply to requests taken at the same edge or later.
module throw_arm_pd_sequencer_core (
	input logic clk,
	input logic arst_n,
	tapd_in_if.sink sensors,
	tapd_out_if.source commands,
	input logic write_en,
	input logic [tapd_pkg::CFG_IDX_W-1:0] write_index,
	input logic [tapd_pkg::DATA_W-1:0] write_data
);

	logic valid_s1;
	tapd_pkg::tapd_in_t sample_s1;
	logic valid_s2;
	tapd_pkg::tapd_law_t law_s2;
	logic out_valid_q;
	tapd_pkg::tapd_out_t out_q;
	logic signed [tapd_pkg::DATA_W-1:0] bearing_q;
	logic [tapd_pkg::WSTAR_W-1:0] wstar_q;
	tapd_pkg::tapd_law_t law;
	tapd_pkg::tapd_out_t result;
	logic out_free;
	logic s2_free;
	logic adv_s1;
	logic adv_s2;

	// Stage flow: each stage loads when it is empty or its contents move on.
	assign out_free = !out_valid_q || commands.ready;
	assign adv_s2 = valid_s2 && out_free;
	assign s2_free = !valid_s2 || out_free;
	assign adv_s1 = valid_s1 && s2_free;
	assign sensors.ready = !valid_s1 || s2_free;

	assign commands.valid = out_valid_q;
	assign commands.payload = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bearing_q <= '0;
			wstar_q <= tapd_pkg::WSTAR_BASE;
		end else if (write_en) begin
			case (write_index)
				tapd_pkg::CFG_TARGET_RANGE: wstar_q <= tapd_pkg::swing_speed(write_data);
				tapd_pkg::CFG_BEARING: bearing_q <= write_data;
				default: begin
				end
			endcase
		end
	end

	tapd_law u_law (
		.clk(clk),
		.arst_n(arst_n),
		.advance(adv_s1),
		.sample(sample_s1),
		.bearing(bearing_q),
		.wstar(wstar_q),
		.law(law)
	);

	tapd_scale u_scale (
		.law(law_s2),
		.result(result)
	);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sensors.ready) begin
				valid_s1 <= sensors.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (sensors.ready && sensors.valid) begin
			sample_s1 <= sensors.payload;
		end
		if (adv_s1) begin
			law_s2 <= law;
		end
		if (adv_s2) begin
			out_q <= result;
		end
	end

	a_release_in_follow: assert property (@(posedge clk) disable iff (!arst_n)
		commands.valid && commands.payload.release_pulse
		|-> commands.payload.phase_now == tapd_pkg::PH_FOLLOW)
		else $error("release pulse without follow-through phase");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sensors.ready |-> (valid_s1 && valid_s2 && out_valid_q))
		else $error("input stalled with a free stage");
	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("request lost between stages");

endmodule

// ===== sim/tb_throw_arm_pd_sequencer_core.sv =====
module tb_throw_arm_pd_sequencer_core;

	localparam int TORQUE_DIV = 1000;
	localparam int SPEED_NUM = 294;
	localparam int SPEED_BASE = 1374;
	localparam int CYCLE_LIMIT = 600000;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;
	logic write_en;
	logic [tapd_pkg::CFG_IDX_W-1:0] write_index;
	logic [tapd_pkg::DATA_W-1:0] write_data;

	tapd_in_if sensors();
	tapd_out_if commands();

	throw_arm_pd_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.sensors(sensors),
		.commands(commands),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data)
	);

	// Shadow copies of the controller state and registers.
	logic [tapd_pkg::PHASE_W-1:0] arm_phase = tapd_pkg::PH_WIND;
	int range_setting = 0;
	int yaw_setting = 0;

	tapd_pkg::tapd_out_t pending_commands[$];
	int fault_count = 0;
	int cycle_count = 0;
	int send_calm = 0;
	int ready_calm = 0;
	int ready_hold = 0;
	int ready_roll;
	tapd_pkg::tapd_out_t want_cmd;
	tapd_pkg::tapd_out_t got_cmd;

	// Clock with an 8 unit period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Torques and phase for one sensor tick; advances the shadow phase.
	function automatic tapd_pkg::tapd_out_t predict_torques(input tapd_pkg::tapd_in_t tick);
		tapd_pkg::tapd_out_t cmd;
		longint ya, yr, ea, er, sa, sr;
		longint speed_goal, elbow_set, yaw_cmd, elbow_cmd, shoulder_cmd;
		logic [tapd_pkg::PHASE_W-1:0] next_phase;
		ya = tick.yaw_angle;
		yr = tick.yaw_rate;
		ea = tick.elbow_angle;
		er = tick.elbow_rate;
		sa = tick.shoulder_angle;
		sr = tick.shoulder_rate;
		speed_goal = longint'(range_setting) * SPEED_NUM / TORQUE_DIV + SPEED_BASE;
		yaw_cmd = ((longint'(yaw_setting) - ya) * tapd_pkg::YAW_KP
			- yr * tapd_pkg::YAW_KD) / TORQUE_DIV;
		elbow_set = (arm_phase == tapd_pkg::PH_WIND) ? tapd_pkg::COCK_ANGLE : 0;
		elbow_cmd = ((elbow_set - ea) * tapd_pkg::ELB_KP - er * tapd_pkg::ELB_KD) / TORQUE_DIV;
		next_phase = arm_phase;
		cmd.release_pulse = 1'b0;
		case (arm_phase)
			tapd_pkg::PH_WIND: begin
				shoulder_cmd = ((tapd_pkg::WIND_ANGLE - sa) * tapd_pkg::WIND_KP
					- sr * tapd_pkg::WIND_KD) / TORQUE_DIV;
				if (sa <= tapd_pkg::WIND_ANGLE + tapd_pkg::SETTLE_BAND &&
					sr <= tapd_pkg::SETTLE_RATE && sr >= -tapd_pkg::SETTLE_RATE)
					next_phase = tapd_pkg::PH_SWING;
			end
			tapd_pkg::PH_SWING: begin
				shoulder_cmd = (speed_goal - sr) * tapd_pkg::SWING_KP / TORQUE_DIV;
				if (sa >= tapd_pkg::RELEASE_AT && sr > 0) begin
					cmd.release_pulse = 1'b1;
					next_phase = tapd_pkg::PH_FOLLOW;
				end
			end
			default: begin
				// Follow-through holds until reset.
				shoulder_cmd = ((0 - sa) * tapd_pkg::FOLLOW_KP
					- sr * tapd_pkg::FOLLOW_KD) / TORQUE_DIV;
			end
		endcase
		arm_phase = next_phase;
		cmd.yaw_torque = yaw_cmd[tapd_pkg::DATA_W-1:0];
		cmd.elbow_torque = elbow_cmd[tapd_pkg::DATA_W-1:0];
		cmd.shoulder_torque = shoulder_cmd[tapd_pkg::DATA_W-1:0];
		cmd.phase_now = next_phase;
		return cmd;
	endfunction

	task automatic report_fault(input string what, input tapd_pkg::tapd_out_t want,
		input tapd_pkg::tapd_out_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s: expected yaw %0d elbow %0d shoulder %0d pulse %0b phase %0d",
				what, want.yaw_torque, want.elbow_torque, want.shoulder_torque,
				want.release_pulse, want.phase_now);
			$display("    got yaw %0d elbow %0d shoulder %0d pulse %0b phase %0d",
				got.yaw_torque, got.elbow_torque, got.shoulder_torque,
				got.release_pulse, got.phase_now);
		end
	endtask

	// Every accepted request queues its expected command.
	always @(posedge clk) begin
		if (arst_n && sensors.valid && sensors.ready)
			pending_commands.push_back(predict_torques(sensors.payload));
	end

	// Check each accepted command, then choose the next ready level.
	always @(posedge clk) begin
		if (arst_n && commands.valid && commands.ready) begin
			got_cmd = commands.payload;
			if (pending_commands.size() == 0) begin
				report_fault("unexpected command", '0, got_cmd);
			end else begin
				want_cmd = pending_commands.pop_front();
				if (got_cmd.yaw_torque !== want_cmd.yaw_torque ||
					got_cmd.elbow_torque !== want_cmd.elbow_torque ||
					got_cmd.shoulder_torque !== want_cmd.shoulder_torque ||
					got_cmd.release_pulse !== want_cmd.release_pulse ||
					got_cmd.phase_now !== want_cmd.phase_now)
					report_fault("command mismatch", want_cmd, got_cmd);
			end
		end
		if (ready_calm > 0) begin
			ready_calm--;
			commands.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
			commands.ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(0, 199);
			if (ready_roll == 0) begin
				ready_calm = $urandom_range(50, 150);
				commands.ready <= 1'b1;
			end else if (ready_roll < 5) begin
				ready_hold = $urandom_range(10, 40);
				commands.ready <= 1'b0;
			end else if (ready_roll < 60) begin
				ready_hold = $urandom_range(0, 2);
				commands.ready <= 1'b0;
			end else begin
				commands.ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Idle cycles ahead of the next request: mostly none or short, a few long.
	function automatic int pick_gap();
		int roll;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll == 0) begin
			send_calm = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 4)
			return $urandom_range(10, 30);
		if (roll < 40)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// Valid stays high on return so a back-to-back request needs no extra edge.
	task automatic send_tick(input tapd_pkg::tapd_in_t tick);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sensors.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensors.valid <= 1'b1;
		sensors.payload <= tick;
		do @(posedge clk); while (!sensors.ready);
	endtask

	// Stop sending and wait until every expected command has come back.
	task automatic drain_commands();
		sensors.valid <= 1'b0;
		do @(posedge clk); while (pending_commands.size() != 0);
	endtask

	task automatic write_reg(input logic [tapd_pkg::CFG_IDX_W-1:0] idx,
		input logic [tapd_pkg::DATA_W-1:0] value);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= value;
		@(posedge clk);
		write_en <= 1'b0;
		if (idx == tapd_pkg::CFG_TARGET_RANGE)
			range_setting = int'(value);
		else
			yaw_setting = int'($signed(value));
		@(posedge clk);
	endtask

	function automatic tapd_pkg::tapd_in_t make_tick(input int ya, input int yr, input int ea,
		input int er, input int sa, input int sr);
		tapd_pkg::tapd_in_t tick;
		tick.yaw_angle = 16'(ya);
		tick.yaw_rate = 16'(yr);
		tick.elbow_angle = 16'(ea);
		tick.elbow_rate = 16'(er);
		tick.shoulder_angle = 16'(sa);
		tick.shoulder_rate = 16'(sr);
		return tick;
	endfunction

	// Full-range word with extra weight on the extremes.
	function automatic logic [tapd_pkg::DATA_W-1:0] any_word();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic tapd_pkg::tapd_in_t random_tick();
		tapd_pkg::tapd_in_t tick;
		tick.yaw_angle = any_word();
		tick.yaw_rate = any_word();
		tick.elbow_angle = any_word();
		tick.elbow_rate = any_word();
		tick.shoulder_angle = any_word();
		tick.shoulder_rate = any_word();
		return tick;
	endfunction

	// Wind-back tick that stays short of settling, often close to the band.
	function automatic tapd_pkg::tapd_in_t windback_tick();
		tapd_pkg::tapd_in_t tick;
		tick = random_tick();
		case ($urandom_range(0, 3))
			0: begin
				tick.shoulder_angle = 16'(-int'($urandom_range(1100, 1329)));
				tick.shoulder_rate = 16'(int'($urandom_range(0, 500)) - 250);
			end
			1: begin
				tick.shoulder_angle = 16'(-int'($urandom_range(1330, 1600)));
				tick.shoulder_rate = 16'($urandom_range(tapd_pkg::SETTLE_RATE + 1, 500));
			end
			default: ;
		endcase
		if (tick.shoulder_angle <= tapd_pkg::WIND_ANGLE + tapd_pkg::SETTLE_BAND &&
			tick.shoulder_rate <= tapd_pkg::SETTLE_RATE &&
			tick.shoulder_rate >= -tapd_pkg::SETTLE_RATE) begin
			if ($urandom_range(0, 1))
				tick.shoulder_rate = 16'($urandom_range(tapd_pkg::SETTLE_RATE + 1, 32767));
			else
				tick.shoulder_rate =
					16'(-int'($urandom_range(tapd_pkg::SETTLE_RATE + 1, 32768)));
		end
		return tick;
	endfunction

	// Swing tick that stays short of release, often close to the release angle.
	function automatic tapd_pkg::tapd_in_t swing_tick();
		tapd_pkg::tapd_in_t tick;
		tick = random_tick();
		case ($urandom_range(0, 3))
			0: tick.shoulder_angle = 16'(-int'($urandom_range(786, 1000)));
			1: begin
				tick.shoulder_angle = 16'(-int'($urandom_range(0, 785)));
				tick.shoulder_rate = 16'(-int'($urandom_range(0, 500)));
			end
			default: ;
		endcase
		if (tick.shoulder_angle >= tapd_pkg::RELEASE_AT && tick.shoulder_rate > 0) begin
			if ($urandom_range(0, 1))
				tick.shoulder_rate = 16'(-int'($urandom_range(0, 32768)));
			else
				tick.shoulder_angle = 16'(-int'($urandom_range(786, 32768)));
		end
		return tick;
	endfunction

	// Wind-back: extremes and near misses of the settle test, under several bearings.
	task automatic test_windback_hold();
		int batch;
		write_reg(tapd_pkg::CFG_BEARING, 16'h7fff);
		write_reg(tapd_pkg::CFG_TARGET_RANGE, 16'hffff);
		send_tick(make_tick(0, 0, 0, 0, 0, 0));
		send_tick(make_tick(32767, 32767, 32767, 32767, 32767, 32767));
		send_tick(make_tick(-32768, -32768, -32768, -32768, -32768, -32768));
		send_tick(make_tick(32767, -32768, -32768, 32767, 32767, -32768));
		send_tick(make_tick(-1, 1, 1100, 0, -1330, 251));
		send_tick(make_tick(1, -1, -1, 1, -1330, -251));
		send_tick(make_tick(-32768, 32767, 32767, -32768, -1329, 0));
		for (batch = 0; batch < 4; batch++) begin
			drain_commands();
			case (batch)
				0: write_reg(tapd_pkg::CFG_BEARING, 16'h8000);
				1: write_reg(tapd_pkg::CFG_BEARING, 16'h0000);
				default: write_reg(tapd_pkg::CFG_BEARING, any_word());
			endcase
			repeat (150) send_tick(windback_tick());
		end
	endtask

	// Settling exactly on the edge of the angle band and the rate band.
	task automatic test_swing_entry();
		send_tick(make_tick(100, -100, 500, -20, -1330, 250));
	endtask

	// Swing under several speed targets, never reaching release.
	task automatic test_swing_drive();
		int batch;
		send_tick(make_tick(0, 0, 0, 0, -786, 32767));
		send_tick(make_tick(32767, 32767, 32767, 32767, 32767, 0));
		send_tick(make_tick(-32768, -32768, -32768, -32768, -785, -32768));
		send_tick(make_tick(-32768, -32768, -32768, -32768, -32768, -32768));
		send_tick(make_tick(32767, -32768, -32768, 32767, 32767, -1));
		send_tick(make_tick(-32768, 32767, 32767, -32768, -32768, 32767));
		for (batch = 0; batch < 4; batch++) begin
			drain_commands();
			case (batch)
				0: write_reg(tapd_pkg::CFG_TARGET_RANGE, 16'h0000);
				1: write_reg(tapd_pkg::CFG_TARGET_RANGE, 16'hffff);
				2: write_reg(tapd_pkg::CFG_TARGET_RANGE, 16'd1000);
				default: write_reg(tapd_pkg::CFG_TARGET_RANGE, any_word());
			endcase
			write_reg(tapd_pkg::CFG_BEARING, any_word());
			repeat (150) send_tick(swing_tick());
		end
	endtask

	// Release on the smallest forward rate right at the release angle.
	task automatic test_release();
		send_tick(make_tick(-200, 300, 0, 0, -785, 1));
	endtask

	// Follow-through holds even when the settle or release tests would pass.
	task automatic test_follow_through();
		int batch;
		send_tick(make_tick(32767, 32767, 32767, 32767, 32767, 32767));
		send_tick(make_tick(-32768, -32768, -32768, -32768, -32768, -32768));
		send_tick(make_tick(0, 0, 1100, 0, -1400, 0));
		send_tick(make_tick(-32768, 32767, 32767, -32768, 0, 100));
		send_tick(make_tick(32767, -32768, -32768, 32767, -32768, 32767));
		for (batch = 0; batch < 4; batch++) begin
			drain_commands();
			case (batch)
				0: write_reg(tapd_pkg::CFG_BEARING, 16'h8000);
				1: write_reg(tapd_pkg::CFG_BEARING, 16'h7fff);
				default: write_reg(tapd_pkg::CFG_BEARING, any_word());
			endcase
			write_reg(tapd_pkg::CFG_TARGET_RANGE, any_word());
			repeat (150) send_tick(random_tick());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		write_en <= 1'b0;
		write_index <= tapd_pkg::CFG_TARGET_RANGE;
		write_data <= '0;
		sensors.valid <= 1'b0;
		sensors.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_windback_hold();
		test_swing_entry();
		test_swing_drive();
		test_release();
		test_follow_through();

		// Let the pipeline empty, then watch a little longer for stray commands.
		drain_commands();
		repeat (20) @(posedge clk);
		if (pending_commands.size() != 0) begin
			fault_count++;
			$display("%0d expected commands never arrived", pending_commands.size());
		end
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tapd_pkg.sv
src/tapd_in_if.sv
src/tapd_out_if.sv
src/tapd_law.sv
src/tapd_scale.sv
src/throw_arm_pd_sequencer_core.sv
sim/tb_throw_arm_pd_sequencer_core.sv
